/* design/mlfs_pkg.sv */
// Shared types and constants of the multilevel feedback scheduler.
// Used by mlfs_ctrl, mlfs_datapath and multilevel_feedback_scheduler.
`timescale 1ns / 1ps
`default_nettype none
package mlfs_pkg;

    localparam int PID_COUNT   = 64;
    localparam int PID_W       = $clog2(PID_COUNT);
    localparam int LEVEL_COUNT = 5;
    localparam int LV_W        = $clog2(LEVEL_COUNT);
    localparam int TOP_LEVEL   = LEVEL_COUNT - 1;
    localparam int Q_W         = LV_W + 1;
    localparam int CNT_W       = $clog2(PID_COUNT + 1);
    localparam int ACT_W       = 3;
    localparam int PRI_W       = 3;
    localparam int ST_W        = 2;
    localparam int VAL_W       = 3;

    localparam logic [PID_W-1:0] IDLE_TASK = PID_W'(1);

    localparam logic [ST_W-1:0] ST_READY   = 2'd0;
    localparam logic [ST_W-1:0] ST_RUNNING = 2'd1;
    localparam logic [ST_W-1:0] ST_BLOCKED = 2'd2;
    localparam logic [ST_W-1:0] ST_ZOMBIE  = 2'd3;
    localparam logic [VAL_W-1:0] VAL_ABSENT = 3'd4;

    typedef enum logic [ACT_W-1:0] {
        ACT_TICK       = 3'd0,
        ACT_YIELD      = 3'd1,
        ACT_REGISTER   = 3'd2,
        ACT_SET_PRI    = 3'd3,
        ACT_SET_STATUS = 3'd4,
        ACT_REMOVE     = 3'd5,
        ACT_QUERY      = 3'd6
    } action_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_TICK_START,
        OP_MOVE,
        OP_APPEND,
        OP_REGISTER,
        OP_SETST,
        OP_REMOVE,
        OP_SELECT,
        OP_RUN
    } dp_op_t;

    typedef enum logic {
        LV_REQ,
        LV_DOWN
    } lv_sel_t;

    typedef struct packed {
        dp_op_t  op;
        lv_sel_t lv_sel;
        logic    fix_status;
        logic    move_en;
        logic    yield;
    } cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic [PID_W-1:0] pid;
        logic [PRI_W-1:0] pri;
        logic [ST_W-1:0]  st;
        logic             pid_present;
        logic             pid_idle;
        logic             pid_is_cur;
        logic             pri_ok;
        logic [ST_W-1:0]  rd_status;
        logic             tgt_present;
        logic             tgt_idle;
        logic             go_tick;
        logic             go_yield;
        logic [PID_W-1:0] cur;
    } dp_status_t;

endpackage
`default_nettype wire

/* design/mlfs_datapath.sv */
// Scheduler datapath: task table memories, level lists, current task, quantum.
// Executes one micro-op per cycle from mlfs_ctrl; depends on mlfs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mlfs_datapath
    import mlfs_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire cmd_t             cmd,
    input  wire logic [ACT_W-1:0] s_action,
    input  wire logic [PID_W-1:0] s_pid,
    input  wire logic [PRI_W-1:0] s_priority_req,
    input  wire logic [ST_W-1:0]  s_status,
    output dp_status_t            stat
);

    // table memories, one read address per cycle, registered read
    logic [LV_W-1:0]  level_mem  [PID_COUNT];
    logic [ST_W-1:0]  status_mem [PID_COUNT];
    logic [PID_W-1:0] next_mem   [PID_COUNT];
    logic [PID_W-1:0] prev_mem   [PID_COUNT];

    logic [LV_W-1:0]  rd_level_reg;
    logic [ST_W-1:0]  rd_status_reg;
    logic [PID_W-1:0] rd_next_reg;
    logic [PID_W-1:0] rd_prev_reg;
    logic [PID_W-1:0] raddr;

    logic             lv_we, st_we, nx_we, pv_we;
    logic [PID_W-1:0] lv_waddr, st_waddr, nx_waddr, pv_waddr;
    logic [LV_W-1:0]  lv_wdata;
    logic [ST_W-1:0]  st_wdata;
    logic [PID_W-1:0] nx_wdata, pv_wdata;

    logic [PID_COUNT-1:0]   valid_reg, valid_next;
    logic [PID_W-1:0]       head_reg [LEVEL_COUNT];
    logic [PID_W-1:0]       head_next [LEVEL_COUNT];
    logic [PID_W-1:0]       tail_reg [LEVEL_COUNT];
    logic [PID_W-1:0]       tail_next [LEVEL_COUNT];
    logic [LEVEL_COUNT-1:0] nonempty_reg, nonempty_next;
    logic [PID_W-1:0]       cur_reg, cur_next;
    logic signed [Q_W-1:0]  quantum_reg, quantum_next;
    logic [CNT_W-1:0]       count_reg, count_next;

    action_t          act_reg;
    logic [PID_W-1:0] pid_reg, tgt_reg, tgt_next;
    logic [PRI_W-1:0] pri_reg;
    logic [ST_W-1:0]  st_reg;
    logic [LV_W-1:0]  lvl_reg, lvl_next;

    logic             do_unlink, do_append, do_prepend;
    logic [LV_W-1:0]  ap_lv, lv_new;
    logic [PID_W-1:0] sel_pid;
    logic             q_at_min;
    logic signed [Q_W-1:0] q_dec;

    assign q_at_min = (quantum_reg == {Q_W{1'b1}});
    assign q_dec    = q_at_min ? quantum_reg : quantum_reg - Q_W'(1);

    always_comb begin
        sel_pid = IDLE_TASK;
        for (int l = 0; l < LEVEL_COUNT; l++) begin
            if (nonempty_reg[l]) begin
                sel_pid = head_reg[l];
            end
        end
    end

    always_comb begin
        if (cmd.lv_sel == LV_REQ) begin
            lv_new = LV_W'(pri_reg);
        end else if (rd_level_reg != '0) begin
            lv_new = rd_level_reg - LV_W'(1);
        end else begin
            lv_new = rd_level_reg;
        end
    end

    always_comb begin
        valid_next    = valid_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        nonempty_next = nonempty_reg;
        cur_next      = cur_reg;
        quantum_next  = quantum_reg;
        count_next    = count_reg;
        tgt_next      = tgt_reg;
        lvl_next      = lvl_reg;
        raddr         = tgt_reg;
        lv_we = 1'b0; lv_waddr = tgt_reg; lv_wdata = lv_new;
        st_we = 1'b0; st_waddr = tgt_reg; st_wdata = ST_READY;
        nx_we = 1'b0; nx_waddr = tgt_reg; nx_wdata = tgt_reg;
        pv_we = 1'b0; pv_waddr = tgt_reg; pv_wdata = tgt_reg;
        do_unlink  = 1'b0;
        do_append  = 1'b0;
        do_prepend = 1'b0;
        ap_lv      = lvl_reg;

        case (cmd.op)
            OP_LATCH: begin
                tgt_next = s_pid;
                raddr    = s_pid;
            end
            OP_TICK_START: begin
                quantum_next = cmd.yield ? $signed({Q_W{1'b1}}) : q_dec;
                tgt_next     = cur_reg;
                raddr        = cur_reg;
            end
            OP_MOVE: begin
                lvl_next = lv_new;
                if (cmd.fix_status && rd_status_reg == ST_RUNNING) begin
                    st_we    = 1'b1;
                    st_wdata = ST_READY;
                end
                if (cmd.move_en) begin
                    lv_we     = 1'b1;
                    do_unlink = (rd_status_reg != ST_BLOCKED);
                end
            end
            OP_APPEND: begin
                do_append = 1'b1;
            end
            OP_REGISTER: begin
                valid_next[pid_reg] = 1'b1;
                lv_we      = 1'b1;
                lv_wdata   = LV_W'(pri_reg);
                st_we      = 1'b1;
                st_wdata   = ST_READY;
                count_next = count_reg + CNT_W'(1);
                do_append  = (pid_reg != IDLE_TASK);
                ap_lv      = LV_W'(pri_reg);
            end
            OP_SETST: begin
                if (st_reg != rd_status_reg) begin
                    st_we    = 1'b1;
                    st_wdata = st_reg;
                    if (st_reg == ST_BLOCKED) begin
                        do_unlink = 1'b1;
                    end else if (rd_status_reg == ST_BLOCKED) begin
                        lv_we        = 1'b1;
                        lv_wdata     = LV_W'(TOP_LEVEL);
                        do_prepend   = 1'b1;
                        quantum_next = '0;
                    end
                end
            end
            OP_REMOVE: begin
                do_unlink = (rd_status_reg != ST_BLOCKED);
                valid_next[pid_reg] = 1'b0;
                count_next = count_reg - CNT_W'(1);
            end
            OP_SELECT: begin
                cur_next = sel_pid;
                tgt_next = sel_pid;
                raddr    = sel_pid;
            end
            OP_RUN: begin
                if (valid_reg[tgt_reg]) begin
                    quantum_next = Q_W'(TOP_LEVEL) - Q_W'(rd_level_reg);
                    st_we        = 1'b1;
                    st_wdata     = ST_RUNNING;
                end else begin
                    quantum_next = Q_W'(TOP_LEVEL);
                end
            end
            default: begin
            end
        endcase

        // list edits on tgt_reg; at most one of these per cycle
        if (do_unlink && nonempty_reg[rd_level_reg]) begin
            if (head_reg[rd_level_reg] == tgt_reg && tail_reg[rd_level_reg] == tgt_reg) begin
                nonempty_next[rd_level_reg] = 1'b0;
            end else begin
                if (head_reg[rd_level_reg] == tgt_reg) begin
                    head_next[rd_level_reg] = rd_next_reg;
                end else begin
                    nx_we    = 1'b1;
                    nx_waddr = rd_prev_reg;
                    nx_wdata = rd_next_reg;
                end
                if (tail_reg[rd_level_reg] == tgt_reg) begin
                    tail_next[rd_level_reg] = rd_prev_reg;
                end else begin
                    pv_we    = 1'b1;
                    pv_waddr = rd_next_reg;
                    pv_wdata = rd_prev_reg;
                end
            end
        end
        if (do_append) begin
            if (nonempty_reg[ap_lv]) begin
                nx_we    = 1'b1;
                nx_waddr = tail_reg[ap_lv];
                nx_wdata = tgt_reg;
                pv_we    = 1'b1;
                pv_waddr = tgt_reg;
                pv_wdata = tail_reg[ap_lv];
            end else begin
                head_next[ap_lv]     = tgt_reg;
                nonempty_next[ap_lv] = 1'b1;
            end
            tail_next[ap_lv] = tgt_reg;
        end
        if (do_prepend) begin
            if (nonempty_reg[TOP_LEVEL]) begin
                pv_we    = 1'b1;
                pv_waddr = head_reg[TOP_LEVEL];
                pv_wdata = tgt_reg;
                nx_we    = 1'b1;
                nx_waddr = tgt_reg;
                nx_wdata = head_reg[TOP_LEVEL];
            end else begin
                tail_next[TOP_LEVEL]     = tgt_reg;
                nonempty_next[TOP_LEVEL] = 1'b1;
            end
            head_next[TOP_LEVEL] = tgt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (lv_we) begin
            level_mem[lv_waddr] <= lv_wdata;
        end
        if (st_we) begin
            status_mem[st_waddr] <= st_wdata;
        end
        if (nx_we) begin
            next_mem[nx_waddr] <= nx_wdata;
        end
        if (pv_we) begin
            prev_mem[pv_waddr] <= pv_wdata;
        end
        rd_level_reg  <= level_mem[raddr];
        rd_status_reg <= status_mem[raddr];
        rd_next_reg   <= next_mem[raddr];
        rd_prev_reg   <= prev_mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            nonempty_reg <= '0;
            cur_reg      <= '0;
            quantum_reg  <= Q_W'(1);
            count_reg    <= '0;
        end else begin
            valid_reg    <= valid_next;
            nonempty_reg <= nonempty_next;
            cur_reg      <= cur_next;
            quantum_reg  <= quantum_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
        tgt_reg  <= tgt_next;
        lvl_reg  <= lvl_next;
        if (cmd.op == OP_LATCH) begin
            act_reg <= action_t'(s_action);
            pid_reg <= s_pid;
            pri_reg <= s_priority_req;
            st_reg  <= s_status;
        end
    end

    always_comb begin
        stat.act         = act_reg;
        stat.pid         = pid_reg;
        stat.pri         = pri_reg;
        stat.st          = st_reg;
        stat.pid_present = valid_reg[pid_reg];
        stat.pid_idle    = (pid_reg == IDLE_TASK);
        stat.pid_is_cur  = (pid_reg == cur_reg);
        stat.pri_ok      = (int'(pri_reg) < LEVEL_COUNT);
        stat.rd_status   = rd_status_reg;
        stat.tgt_present = valid_reg[tgt_reg];
        stat.tgt_idle    = (tgt_reg == IDLE_TASK);
        stat.go_yield    = (count_reg != '0);
        stat.go_tick     = (count_reg != '0) && (q_dec[Q_W-1] || q_dec == '0);
        stat.cur         = cur_reg;
    end

endmodule
`default_nettype wire

/* design/mlfs_ctrl.sv */
// Scheduler controller: request sequencing state machine and result register.
// Drives mlfs_datapath by micro-op commands; depends on mlfs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mlfs_ctrl
    import mlfs_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_ok,
    output logic [VAL_W-1:0]       m_value,
    output logic [PID_W-1:0]       m_running_pid,
    output logic                   m_switched,
    input  wire dp_status_t        stat,
    output cmd_t                   cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_TSTART, S_TCUR, S_APPEND, S_SEL, S_RUN, S_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic             ok_reg, ok_next, sw_reg, sw_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic             m_valid_reg, m_valid_next;
    logic             m_ok_reg, m_ok_next, m_sw_reg, m_sw_next;
    logic [VAL_W-1:0] m_val_reg, m_val_next;
    logic [PID_W-1:0] m_pid_reg, m_pid_next;
    logic             go;

    assign go = (action_t'(stat.act) == ACT_TICK) ? stat.go_tick : stat.go_yield;

    always_comb begin
        state_next   = state_reg;
        ok_next      = ok_reg;
        sw_next      = sw_reg;
        val_next     = val_reg;
        m_valid_next = m_valid_reg;
        m_ok_next    = m_ok_reg;
        m_sw_next    = m_sw_reg;
        m_val_next   = m_val_reg;
        m_pid_next   = m_pid_reg;
        cmd          = '{op: OP_NONE, lv_sel: LV_REQ, fix_status: 1'b0,
                         move_en: 1'b0, yield: 1'b0};
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_LATCH;
                    ok_next    = 1'b0;
                    sw_next    = 1'b0;
                    val_next   = '0;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = S_DONE;
                case (action_t'(stat.act))
                    ACT_TICK, ACT_YIELD: begin
                        ok_next    = 1'b1;
                        state_next = S_TSTART;
                    end
                    ACT_REGISTER: begin
                        if (!stat.pid_present && stat.pri_ok) begin
                            cmd.op  = OP_REGISTER;
                            ok_next = 1'b1;
                        end
                    end
                    ACT_SET_PRI: begin
                        if (stat.pid_present && !stat.pid_idle && stat.pri_ok) begin
                            cmd.op      = OP_MOVE;
                            cmd.lv_sel  = LV_REQ;
                            cmd.move_en = 1'b1;
                            ok_next     = 1'b1;
                            val_next    = stat.pri;
                            if (stat.rd_status != ST_BLOCKED) begin
                                state_next = S_APPEND;
                            end
                        end
                    end
                    ACT_SET_STATUS: begin
                        if (stat.pid_present && !stat.pid_idle && stat.st != ST_RUNNING
                            && stat.st != ST_ZOMBIE && stat.rd_status != ST_ZOMBIE) begin
                            cmd.op   = OP_SETST;
                            ok_next  = 1'b1;
                            val_next = {1'b0, stat.st};
                        end
                    end
                    ACT_REMOVE: begin
                        if (stat.pid_present && !stat.pid_idle) begin
                            cmd.op  = OP_REMOVE;
                            ok_next = 1'b1;
                            if (stat.pid_is_cur) begin
                                state_next = S_TSTART;
                            end
                        end
                    end
                    ACT_QUERY: begin
                        ok_next  = 1'b1;
                        val_next = stat.pid_present ? {1'b0, stat.rd_status} : VAL_ABSENT;
                    end
                    default: begin
                    end
                endcase
            end
            S_TSTART: begin
                cmd.op     = OP_TICK_START;
                cmd.yield  = (action_t'(stat.act) != ACT_TICK);
                state_next = go ? S_TCUR : S_DONE;
            end
            S_TCUR: begin
                // current task: running -> ready, then drop one level
                state_next = S_SEL;
                if (stat.tgt_present) begin
                    cmd.op         = OP_MOVE;
                    cmd.lv_sel     = LV_DOWN;
                    cmd.fix_status = 1'b1;
                    cmd.move_en    = !stat.tgt_idle;
                    if (!stat.tgt_idle && stat.rd_status != ST_BLOCKED) begin
                        state_next = S_APPEND;
                    end
                end
            end
            S_APPEND: begin
                cmd.op     = OP_APPEND;
                state_next = (action_t'(stat.act) == ACT_SET_PRI) ? S_DONE : S_SEL;
            end
            S_SEL: begin
                cmd.op     = OP_SELECT;
                state_next = S_RUN;
            end
            S_RUN: begin
                cmd.op     = OP_RUN;
                sw_next    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_ok_next    = ok_reg;
                    m_val_next   = val_reg;
                    m_sw_next    = sw_reg;
                    m_pid_next   = stat.cur;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        ok_reg    <= ok_next;
        sw_reg    <= sw_next;
        val_reg   <= val_next;
        m_ok_reg  <= m_ok_next;
        m_sw_reg  <= m_sw_next;
        m_val_reg <= m_val_next;
        m_pid_reg <= m_pid_next;
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_ok          = m_ok_reg;
    assign m_value       = m_val_reg;
    assign m_running_pid = m_pid_reg;
    assign m_switched    = m_sw_reg;

endmodule
`default_nettype wire

/* design/multilevel_feedback_scheduler.sv */
// Multilevel feedback scheduler top level: controller plus datapath.
// A request is latched, then decoded. Register, set status, query, remove of a task that
// is not current and refused requests go straight to the result; set priority of a queued
// task first appends it; a tick or yield updates the quantum and, on a reschedule, requeues
// the current task, selects and runs the next. Only one request is in flight. Reset clears
// the FSM, valid bits, level flags and counters; tables hold no reset.
`timescale 1ns / 1ps
`default_nettype none
module multilevel_feedback_scheduler
    import mlfs_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [ACT_W-1:0] s_action,
    input  wire logic [PID_W-1:0] s_pid,
    input  wire logic [PRI_W-1:0] s_priority_req,
    input  wire logic [ST_W-1:0]  s_status,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic                  m_ok,
    output logic [VAL_W-1:0]      m_value,
    output logic [PID_W-1:0]      m_running_pid,
    output logic                  m_switched
);

    cmd_t       cmd;
    dp_status_t stat;

    mlfs_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ok          (m_ok),
        .m_value       (m_value),
        .m_running_pid (m_running_pid),
        .m_switched    (m_switched),
        .stat          (stat),
        .cmd           (cmd)
    );

    mlfs_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .s_action       (s_action),
        .s_pid          (s_pid),
        .s_priority_req (s_priority_req),
        .s_status       (s_status),
        .stat           (stat)
    );

    // one request in flight at a time
    a_single_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while another is in progress");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_running_pid)))
        else $error("stalled result dropped or changed");

    a_error_no_switch: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ok) |-> (!m_switched && m_value == '0))
        else $error("refused request reports a switch or a value");

endmodule
`default_nettype wire
